@@ src/kbd_rpt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbd_rpt_pkg: shared constants for the keyboard report builder
// Key code ranges, modifier masks and the ASCII to HID usage table.
// ----------------------------------------------------------------------------
package kbd_rpt_pkg;

    localparam int unsigned KEY_W       = 8;
    localparam int unsigned USAGE_W     = 8;
    localparam int unsigned OUT_SLOTS   = 6;

    localparam logic [KEY_W-1:0]   RAW_BASE   = 8'd136;
    localparam logic [KEY_W-1:0]   MOD_BASE   = 8'd128;
    localparam logic [USAGE_W-1:0] LEFT_SHIFT = 8'h02;
    localparam logic [USAGE_W-1:0] USAGE_MASK = 8'h7F;

    // func codes
    localparam logic FUNC_PRESS   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // ASCII to usage; bit 7 flags a shifted character, 0 means unmapped
    localparam logic [USAGE_W-1:0] ASCII_USAGE [128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
        8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
        8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
        8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
        8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
        8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
        8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
        8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
        8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
        8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
        8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
        8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
    };

endpackage

@@ src/keyboard_report_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_report_builder: HID boot keyboard report from key events
// Keeps the modifier byte and the key slots and reports them per event.
// ----------------------------------------------------------------------------
// A key event (i_func, i_key) is taken when i_start is high and o_busy is low;
// o_busy is high only during reset, so one event per clock is accepted. The
// event is registered, decoded and applied to the report state in the next
// cycle: its result appears with o_valid at the first clock edge after the
// accepting edge and is shown for exactly one cycle, so the receiver must take
// it then. The slot lookup (parallel compares plus first-empty pick) and the
// ASCII table read sit in that single stage. o_sent low marks a rejected event
// (unmapped character, or a press with all slots full); the report fields
// always carry the current contents. Slot outputs beyond SLOT_COUNT read 0.
// ----------------------------------------------------------------------------
module keyboard_report_builder #(
    parameter int unsigned SLOT_COUNT = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic       i_func,
    input  logic [7:0] i_key,
    output logic       o_valid,
    output logic       o_sent,
    output logic [7:0] o_modifier_bits,
    output logic [7:0] o_slot0,
    output logic [7:0] o_slot1,
    output logic [7:0] o_slot2,
    output logic [7:0] o_slot3,
    output logic [7:0] o_slot4,
    output logic [7:0] o_slot5
);

    localparam int unsigned UW = kbd_rpt_pkg::USAGE_W;

    // input stage
    logic                     r_in_valid;
    logic                     r_func;
    logic [kbd_rpt_pkg::KEY_W-1:0] r_key;

    // report state, which doubles as the result register
    logic                              r_valid;
    logic                              r_sent;
    logic [UW-1:0]                     r_mod;
    logic [SLOT_COUNT-1:0][UW-1:0]     r_slots;
    logic                              n_sent;
    logic [UW-1:0]                     n_mod;
    logic [SLOT_COUNT-1:0][UW-1:0]     n_slots;

    // decode
    logic [UW-1:0]         w_tab;
    logic [UW-1:0]         w_usage;
    logic                  w_mapped;
    logic [SLOT_COUNT-1:0] w_empty;
    logic [SLOT_COUNT-1:0] w_match;
    logic [SLOT_COUNT-1:0] w_first;

    assign o_busy = ~i_rst_n;

    // capture the accepted event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start;
        end
        if (i_start) begin
            r_func <= i_func;
            r_key  <= i_key;
        end
    end

    // key code decode to usage
    assign w_tab = kbd_rpt_pkg::ASCII_USAGE[r_key[6:0]];

    always_comb begin
        w_usage  = '0;
        w_mapped = 1'b1;
        if (r_key >= kbd_rpt_pkg::RAW_BASE) begin
            w_usage = r_key - kbd_rpt_pkg::RAW_BASE;
        end else if (r_key >= kbd_rpt_pkg::MOD_BASE) begin
            w_usage = '0;
        end else begin
            w_usage  = w_tab & kbd_rpt_pkg::USAGE_MASK;
            w_mapped = (w_tab != '0);
        end
    end

    // parallel slot compares and first-empty pick
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            w_empty[i] = (r_slots[i] == '0);
            w_match[i] = (r_slots[i] == w_usage);
        end
    end

    assign w_first = w_empty & (~w_empty + SLOT_COUNT'(1));

    // apply the event to the report state
    always_comb begin
        n_sent  = 1'b1;
        n_mod   = r_mod;
        n_slots = r_slots;
        if (!w_mapped) begin
            n_sent = 1'b0;
        end else begin
            // modifier update
            if (r_key < kbd_rpt_pkg::RAW_BASE) begin
                if (r_key >= kbd_rpt_pkg::MOD_BASE) begin
                    if (r_func == kbd_rpt_pkg::FUNC_RELEASE) begin
                        n_mod = r_mod & ~(UW'(1) << r_key[2:0]);
                    end else begin
                        n_mod = r_mod | (UW'(1) << r_key[2:0]);
                    end
                end else if (w_tab[UW-1]) begin
                    if (r_func == kbd_rpt_pkg::FUNC_RELEASE) begin
                        n_mod = r_mod & ~kbd_rpt_pkg::LEFT_SHIFT;
                    end else begin
                        n_mod = r_mod | kbd_rpt_pkg::LEFT_SHIFT;
                    end
                end
            end
            // slot update
            if (r_func == kbd_rpt_pkg::FUNC_RELEASE) begin
                if (w_usage != '0) begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (w_match[i]) begin
                            n_slots[i] = '0;
                        end
                    end
                end
            end else if (w_match == '0) begin
                if (w_empty == '0) begin
                    n_sent = 1'b0;
                end else begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (w_first[i]) begin
                            n_slots[i] = w_usage;
                        end
                    end
                end
            end
        end
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sent  <= 1'b0;
            r_mod   <= '0;
            r_slots <= '0;
        end else begin
            r_valid <= r_in_valid;
            if (r_in_valid) begin
                r_sent  <= n_sent;
                r_mod   <= n_mod;
                r_slots <= n_slots;
            end
        end
    end

    // report outputs; slots past SLOT_COUNT read as empty
    logic [kbd_rpt_pkg::OUT_SLOTS-1:0][UW-1:0] w_slot_out;

    for (genvar j = 0; j < kbd_rpt_pkg::OUT_SLOTS; j++) begin : g_out
        if (j < SLOT_COUNT) begin : g_used
            assign w_slot_out[j] = r_slots[j];
        end else begin : g_unused
            assign w_slot_out[j] = '0;
        end
    end

    assign o_valid         = r_valid;
    assign o_sent          = r_sent;
    assign o_modifier_bits = r_mod;
    assign o_slot0         = w_slot_out[0];
    assign o_slot1         = w_slot_out[1];
    assign o_slot2         = w_slot_out[2];
    assign o_slot3         = w_slot_out[3];
    assign o_slot4         = w_slot_out[4];
    assign o_slot5         = w_slot_out[5];

`ifndef SYNTHESIS
    // every result comes from an event held in the input stage
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_in_valid))
        else $error("result without a registered event");

    // a rejected event leaves the key slots untouched
    a_reject_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_sent) |-> $stable(r_slots))
        else $error("rejected event changed the key slots");

    // a release is only rejected when the character is unmapped
    a_release_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_sent && $past(r_func)) |->
            ($past(r_key) < kbd_rpt_pkg::MOD_BASE &&
             kbd_rpt_pkg::ASCII_USAGE[$past(r_key[6:0])] == '0))
        else $error("mapped release was rejected");
`endif

endmodule

@@ verif/keyboard_report_builder_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_report_builder_checker: report predictor and comparator
// Watches accepted key events, predicts the HID report each one produces
// and compares it field by field with the strobed result, in order.
// ----------------------------------------------------------------------------
module keyboard_report_builder_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic       i_func,
    input  logic [7:0] i_key,
    input  logic       i_valid,
    input  logic       i_sent,
    input  logic [7:0] i_modifier_bits,
    input  logic [7:0] i_slot0,
    input  logic [7:0] i_slot1,
    input  logic [7:0] i_slot2,
    input  logic [7:0] i_slot3,
    input  logic [7:0] i_slot4,
    input  logic [7:0] i_slot5,
    output int         o_errors,
    output int         o_pending
);

    localparam int unsigned SLOT_COUNT = 6;
    localparam int unsigned UW         = kbd_rpt_pkg::USAGE_W;
    localparam int unsigned NOUT       = kbd_rpt_pkg::OUT_SLOTS;

    typedef struct {
        logic                    sent;
        logic [UW-1:0]           modifier_bits;
        logic [NOUT-1:0][UW-1:0] slots;
    } t_report;

    // predicted keyboard state
    logic [UW-1:0] mod_byte;
    logic [UW-1:0] held_keys [SLOT_COUNT];

    t_report report_q [$];
    int      mismatch_cnt;

    initial begin
        mismatch_cnt = 0;
    end

    // apply one key event to the predicted state, return the report it gives
    function automatic t_report apply_key_event(input logic func,
                                                input logic [7:0] key);
        t_report       rpt;
        logic [UW-1:0] usage;
        logic [UW-1:0] mbit;
        logic          found;
        int            free_idx;
        rpt.sent = 1'b1;
        usage    = '0;
        if (key >= kbd_rpt_pkg::RAW_BASE) begin
            usage = key - kbd_rpt_pkg::RAW_BASE;
        end else if (key >= kbd_rpt_pkg::MOD_BASE) begin
            mbit = 8'd1 << key[2:0];
            if (func == kbd_rpt_pkg::FUNC_RELEASE) mod_byte = mod_byte & ~mbit;
            else                                   mod_byte = mod_byte | mbit;
        end else begin
            usage = kbd_rpt_pkg::ASCII_USAGE[key[6:0]];
            if (usage == '0) begin
                // unmapped character: rejected, state untouched
                rpt.sent = 1'b0;
            end else if (usage[7]) begin
                if (func == kbd_rpt_pkg::FUNC_RELEASE)
                    mod_byte = mod_byte & ~kbd_rpt_pkg::LEFT_SHIFT;
                else
                    mod_byte = mod_byte | kbd_rpt_pkg::LEFT_SHIFT;
                usage = usage & kbd_rpt_pkg::USAGE_MASK;
            end
        end

        if (rpt.sent) begin
            if (func == kbd_rpt_pkg::FUNC_RELEASE) begin
                // clear every matching slot; usage 0 clears nothing
                if (usage != '0) begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                        if (held_keys[i] == usage) held_keys[i] = '0;
                end
            end else begin
                // usage 0 counts as present while any slot is empty
                found    = 1'b0;
                free_idx = -1;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (held_keys[i] == usage) found = 1'b1;
                    if (held_keys[i] == '0 && free_idx < 0) free_idx = i;
                end
                if (!found) begin
                    if (free_idx < 0) rpt.sent = 1'b0;
                    else              held_keys[free_idx] = usage;
                end
            end
        end

        rpt.modifier_bits = mod_byte;
        for (int j = 0; j < NOUT; j++)
            rpt.slots[j] = (j < SLOT_COUNT) ? held_keys[j] : '0;
        return rpt;
    endfunction

    task automatic flag_mismatch(input string what, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what,
                     exp_v, act_v);
    endtask

    // compare results, then record the transaction accepted at this edge
    always @(posedge i_clk) begin : watch
        t_report got;
        t_report want;
        if (!i_rst_n) begin
            mod_byte = '0;
            for (int i = 0; i < SLOT_COUNT; i++) held_keys[i] = '0;
            report_q.delete();
        end else begin
            if (i_valid) begin
                got.sent          = i_sent;
                got.modifier_bits = i_modifier_bits;
                got.slots         = {i_slot5, i_slot4, i_slot3, i_slot2, i_slot1, i_slot0};
                if (report_q.size() == 0) begin
                    flag_mismatch("unexpected result, sent", 8'h00, {7'd0, got.sent});
                end else begin
                    want = report_q.pop_front();
                    if (got.sent !== want.sent)
                        flag_mismatch("sent", {7'd0, want.sent}, {7'd0, got.sent});
                    if (got.modifier_bits !== want.modifier_bits)
                        flag_mismatch("modifier_bits", want.modifier_bits,
                                      got.modifier_bits);
                    for (int j = 0; j < NOUT; j++)
                        if (got.slots[j] !== want.slots[j])
                            flag_mismatch($sformatf("slot%0d", j), want.slots[j],
                                          got.slots[j]);
                end
            end
            if (i_start && !i_busy)
                report_q.push_back(apply_key_event(i_func, i_key));
        end
        o_errors  <= mismatch_cnt;
        o_pending <= report_q.size();
    end

endmodule

@@ verif/keyboard_report_builder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_report_builder_tb: key event stimulus and verdict
// Drives directed corner events, then phases of random key press/release
// traffic with varying sender gaps; the checker scores every report.
// ----------------------------------------------------------------------------
module keyboard_report_builder_tb;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic       i_func;
    logic [7:0] i_key;
    logic       o_busy;
    logic       o_valid;
    logic       o_sent;
    logic [7:0] o_modifier_bits;
    logic [7:0] o_slot0, o_slot1, o_slot2, o_slot3, o_slot4, o_slot5;

    int         error_cnt;
    int         pending_cnt;
    int         gap_pct;
    logic [7:0] down_keys [$];

    keyboard_report_builder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_func          (i_func),
        .i_key           (i_key),
        .o_valid         (o_valid),
        .o_sent          (o_sent),
        .o_modifier_bits (o_modifier_bits),
        .o_slot0         (o_slot0),
        .o_slot1         (o_slot1),
        .o_slot2         (o_slot2),
        .o_slot3         (o_slot3),
        .o_slot4         (o_slot4),
        .o_slot5         (o_slot5)
    );

    keyboard_report_builder_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_busy          (o_busy),
        .i_func          (i_func),
        .i_key           (i_key),
        .i_valid         (o_valid),
        .i_sent          (o_sent),
        .i_modifier_bits (o_modifier_bits),
        .i_slot0         (o_slot0),
        .i_slot1         (o_slot1),
        .i_slot2         (o_slot2),
        .i_slot3         (o_slot3),
        .i_slot4         (o_slot4),
        .i_slot5         (o_slot5),
        .o_errors        (error_cnt),
        .o_pending       (pending_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one key event transaction, with an optional idle gap ahead of it
    task automatic send_event(input logic func, input logic [7:0] key);
        int gap;
        if ($urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 4);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_func  <= func;
        i_key   <= key;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // hold off until every predicted report has been seen
    task automatic drain_reports();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
    endtask

    // mostly press/release pairs on recently pressed keys, plus noise
    task automatic send_random_event();
        logic       func;
        logic [7:0] key;
        int         idx;
        int         pick;
        if ($urandom_range(0, 99) < 35 && down_keys.size() > 0) begin
            idx  = $urandom_range(0, down_keys.size() - 1);
            func = kbd_rpt_pkg::FUNC_RELEASE;
            key  = down_keys[idx];
            down_keys.delete(idx);
        end else begin
            func = ($urandom_range(0, 99) < 25) ? kbd_rpt_pkg::FUNC_RELEASE
                                                : kbd_rpt_pkg::FUNC_PRESS;
            pick = $urandom_range(0, 99);
            if (pick < 45)      key = 8'($urandom_range(32, 126));
            else if (pick < 60) key = 8'($urandom_range(128, 135));
            else if (pick < 75) key = kbd_rpt_pkg::RAW_BASE + 8'($urandom_range(0, 15));
            else                key = 8'($urandom_range(0, 255));
            if (func == kbd_rpt_pkg::FUNC_PRESS) begin
                down_keys.push_back(key);
                if (down_keys.size() > 12) void'(down_keys.pop_front());
            end
        end
        send_event(func, key);
    endtask

    initial begin
        int phase_gap [4];
        phase_gap = '{0, 60, 8, 0};
        gap_pct   = 0;
        i_rst_n   <= 1'b0;
        i_start   <= 1'b0;
        i_func    <= kbd_rpt_pkg::FUNC_PRESS;
        i_key     <= 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_event(kbd_rpt_pkg::FUNC_PRESS,   8'h00);     // unmapped control char
        send_event(kbd_rpt_pkg::FUNC_RELEASE, 8'h7F);     // unmapped DEL, release side
        send_event(kbd_rpt_pkg::FUNC_PRESS,   8'h41);     // 'A': shifted, sets left shift
        send_event(kbd_rpt_pkg::FUNC_PRESS,   8'h61);     // 'a': same usage, already held
        send_event(kbd_rpt_pkg::FUNC_RELEASE, 8'h61);     // clears the slot
        send_event(kbd_rpt_pkg::FUNC_PRESS,   kbd_rpt_pkg::MOD_BASE); // lowest modifier
        send_event(kbd_rpt_pkg::FUNC_PRESS,   8'd135);    // highest modifier bit
        send_event(kbd_rpt_pkg::FUNC_PRESS,   kbd_rpt_pkg::RAW_BASE); // raw 0, free slots
        send_event(kbd_rpt_pkg::FUNC_PRESS,   8'hFF);     // largest raw usage
        send_event(kbd_rpt_pkg::FUNC_PRESS,   8'h31);
        send_event(kbd_rpt_pkg::FUNC_PRESS,   8'h32);
        send_event(kbd_rpt_pkg::FUNC_PRESS,   8'h33);
        send_event(kbd_rpt_pkg::FUNC_PRESS,   8'h34);
        send_event(kbd_rpt_pkg::FUNC_PRESS,   8'h35);     // all six slots now in use
        send_event(kbd_rpt_pkg::FUNC_PRESS,   8'h7A);     // no free slot: rejected
        send_event(kbd_rpt_pkg::FUNC_PRESS,   kbd_rpt_pkg::RAW_BASE); // raw 0, full
        send_event(kbd_rpt_pkg::FUNC_PRESS,   8'd129);    // modifier with slots full
        send_event(kbd_rpt_pkg::FUNC_PRESS,   8'h31);     // already held while full
        send_event(kbd_rpt_pkg::FUNC_RELEASE, kbd_rpt_pkg::RAW_BASE); // release of usage 0
        send_event(kbd_rpt_pkg::FUNC_RELEASE, kbd_rpt_pkg::MOD_BASE);
        send_event(kbd_rpt_pkg::FUNC_RELEASE, 8'd135);
        send_event(kbd_rpt_pkg::FUNC_RELEASE, 8'hFF);
        send_event(kbd_rpt_pkg::FUNC_PRESS,   8'h0A);     // newline
        send_event(kbd_rpt_pkg::FUNC_RELEASE, 8'h21);     // '!': clears shift and '1' slot
        drain_reports();

        // random phases with different sender gap rates
        for (int p = 0; p < 4; p++) begin
            gap_pct = phase_gap[p];
            for (int n = 0; n < 310; n++) send_random_event();
            drain_reports();
        end

        i_start <= 1'b0;
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (error_cnt == 0) begin
            $display("keyboard_report_builder_tb: done, clean");
        end else begin
            $display("keyboard_report_builder_tb: done, errors");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("keyboard_report_builder_tb: done, errors");
        $finish;
    end

endmodule
